// ===== src/lcq_pkg.sv =====
// Package with the command, status, payload and sequencer state types of the linked chunk queue.
`timescale 1ns / 1ps
package lcq_pkg;
	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_DESTROY = 2'd1,
		CMD_ENQ     = 2'd2,
		CMD_DEQ     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_ILLEGAL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] queue_id;
		logic [7:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic [5:0] new_queue;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_WALK_RD,
		S_WALK,
		S_DONE
	} state_t;
endpackage

// ===== src/linked_chunk_multi_byte_queue.sv =====
// Top level of the linked chunk queue: sequencer, memories and output register.
// Each item passes through the pointer read, the execute and write back, and the output load;
// destroy of a queue with more than one chunk first walks its chain, reading and freeing one
// chunk at a time. No new item is accepted until the result is loaded into the output
// register, and a result that waits for out_ready holds the sequencer.
// Reset rebuilds the free chunk chain and the free id stack in a sweep over the chunk and
// queue slots, during which no item is accepted.
`timescale 1ns / 1ps
module linked_chunk_multi_byte_queue #(
	parameter int NUM_CHUNK_SLOTS = 256,
	parameter int NUM_QUEUE_SLOTS = 64,
	parameter int BYTES_PER_CHUNK = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lcq_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lcq_pkg::out_item_t   out_data
);
	localparam int CW = (NUM_CHUNK_SLOTS > 1) ? $clog2(NUM_CHUNK_SLOTS) : 1;
	localparam int QW = (NUM_QUEUE_SLOTS > 1) ? $clog2(NUM_QUEUE_SLOTS) : 1;
	localparam int OW = (BYTES_PER_CHUNK > 1) ? $clog2(BYTES_PER_CHUNK) : 1;
	localparam int SW = CW + OW;
	localparam int QCW = $clog2(NUM_QUEUE_SLOTS + 1);
	localparam int CCW = $clog2(NUM_CHUNK_SLOTS + 1);
	localparam int INIT_N = (NUM_CHUNK_SLOTS > NUM_QUEUE_SLOTS) ? NUM_CHUNK_SLOTS
		: NUM_QUEUE_SLOTS;
	localparam int IW = $clog2(INIT_N + 1);
	localparam logic [OW-1:0] LASTOFF = OW'(BYTES_PER_CHUNK - 1);

	// Positions are held as chunk and offset, the byte store is addressed chunk-major.
	logic [7:0]   bytes_mem [NUM_CHUNK_SLOTS * (1 << OW)];
	logic [CW-1:0] link_mem [NUM_CHUNK_SLOTS];
	logic [2*SW-1:0] ptr_mem [NUM_QUEUE_SLOTS];
	logic [QW-1:0] fq_mem  [NUM_QUEUE_SLOTS];
	logic [NUM_QUEUE_SLOTS-1:0] nonempty_q, in_use_q;

	lcq_pkg::state_t state_q, state_d;
	lcq_pkg::in_item_t cur_q;
	logic [CW-1:0] fc_head_q;
	logic [CCW-1:0] fc_cnt_q;
	logic [QCW-1:0] fq_cnt_q;
	logic init_q;
	logic [IW-1:0] init_cnt_q;

	logic [2*SW-1:0] ptr_rd_s1;
	logic [7:0]      byte_rd_s1;
	logic [CW-1:0]   link_rd_s1;
	logic [QW-1:0]   fq_rd_s1;
	logic [CW-1:0]   walk_c_q;

	lcq_pkg::out_item_t res_d, res_q;

	logic [CW-1:0] hc_rd, link_ra;
	logic [OW-1:0] ho_rd;
	logic [2*SW-1:0] ptr_mem_rd;
	logic [CW-1:0] ptr_mem_hc;
	logic [OW-1:0] ptr_mem_ho;

	logic [CW-1:0] hc, tc;
	logic [OW-1:0] ho, to;
	assign hc = ptr_rd_s1[2*SW-1 -: CW];
	assign ho = ptr_rd_s1[SW+OW-1 -: OW];
	assign tc = ptr_rd_s1[SW-1 -: CW];
	assign to = ptr_rd_s1[OW-1:0];

	logic [QW-1:0] qid;
	logic q_ok;
	assign qid = cur_q.queue_id[QW-1:0];
	assign q_ok = (32'(cur_q.queue_id) < NUM_QUEUE_SLOTS) && in_use_q[qid];

	logic nomem_chunk;
	assign nomem_chunk = (fc_cnt_q == '0);

	logic out_load;
	assign out_load = (state_q == lcq_pkg::S_DONE) && (!out_valid || out_ready);

	assign in_ready = (state_q == lcq_pkg::S_IDLE) && !init_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcq_pkg::S_IDLE:    if (in_valid && in_ready) state_d = lcq_pkg::S_READ;
			lcq_pkg::S_READ:    state_d = lcq_pkg::S_EXEC;
			lcq_pkg::S_EXEC:
				if (cur_q.cmd == lcq_pkg::CMD_DESTROY && q_ok && nonempty_q[qid] && hc != tc)
					state_d = lcq_pkg::S_WALK_RD;
				else state_d = lcq_pkg::S_DONE;
			lcq_pkg::S_WALK_RD: state_d = lcq_pkg::S_WALK;
			lcq_pkg::S_WALK:
				state_d = (walk_c_q == tc) ? lcq_pkg::S_DONE : lcq_pkg::S_WALK_RD;
			lcq_pkg::S_DONE:    state_d = out_load ? lcq_pkg::S_IDLE : lcq_pkg::S_DONE;
			default:            state_d = lcq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		res_d = '0;
		res_d.status = lcq_pkg::ST_OK;
		unique case (cur_q.cmd)
			lcq_pkg::CMD_CREATE:
				if (fq_cnt_q == '0) res_d.status = lcq_pkg::ST_NOMEM;
				else res_d.new_queue = 6'(fq_rd_s1);
			lcq_pkg::CMD_DESTROY:
				if (!q_ok) res_d.status = lcq_pkg::ST_ILLEGAL;
			lcq_pkg::CMD_ENQ:
				if (!q_ok) res_d.status = lcq_pkg::ST_ILLEGAL;
				else if ((!nonempty_q[qid] || to == LASTOFF) && nomem_chunk)
					res_d.status = lcq_pkg::ST_NOMEM;
			lcq_pkg::CMD_DEQ:
				if (!q_ok || !nonempty_q[qid]) res_d.status = lcq_pkg::ST_ILLEGAL;
				else res_d.data_out = byte_rd_s1;
			default: ;
		endcase
	end

	// Memory read ports, registered.
	always_ff @(posedge clk) begin
		ptr_rd_s1  <= ptr_mem[qid];
		fq_rd_s1   <= fq_mem[fq_cnt_q[QW-1:0] - QW'(1)];
		byte_rd_s1 <= bytes_mem[{hc_rd, ho_rd}];
		link_rd_s1 <= link_mem[link_ra];
	end

	always_comb begin
		hc_rd = hc;
		ho_rd = ho;
		if (state_q == lcq_pkg::S_READ) begin
			hc_rd = ptr_mem_hc;
			ho_rd = ptr_mem_ho;
		end
		if (state_q == lcq_pkg::S_READ)
			link_ra = (cur_q.cmd == lcq_pkg::CMD_ENQ) ? fc_head_q : ptr_mem_hc;
		else link_ra = walk_c_q;
	end
	assign ptr_mem_hc = ptr_mem_rd[2*SW-1 -: CW];
	assign ptr_mem_ho = ptr_mem_rd[SW+OW-1 -: OW];
	// Head pointer is read early through a separate registered copy.
	always_ff @(posedge clk) begin
		if (state_q == lcq_pkg::S_IDLE) ptr_mem_rd <= ptr_mem[in_data.queue_id[QW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcq_pkg::S_IDLE;
			init_q <= 1'b1;
			init_cnt_q <= '0;
			fc_head_q <= '0;
			fc_cnt_q <= CCW'(NUM_CHUNK_SLOTS);
			fq_cnt_q <= QCW'(NUM_QUEUE_SLOTS);
			nonempty_q <= '0;
			in_use_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (init_q) begin
				init_cnt_q <= init_cnt_q + 1'b1;
				if (32'(init_cnt_q) == INIT_N - 1) init_q <= 1'b0;
			end
			if (state_q == lcq_pkg::S_EXEC) begin
				unique case (cur_q.cmd)
					lcq_pkg::CMD_CREATE: if (fq_cnt_q != '0) begin
						fq_cnt_q <= fq_cnt_q - 1'b1;
						in_use_q[fq_rd_s1] <= 1'b1;
						nonempty_q[fq_rd_s1] <= 1'b0;
					end
					lcq_pkg::CMD_DESTROY: if (q_ok) begin
						nonempty_q[qid] <= 1'b0;
						in_use_q[qid] <= 1'b0;
						if (fq_cnt_q < QCW'(NUM_QUEUE_SLOTS)) fq_cnt_q <= fq_cnt_q + 1'b1;
						if (nonempty_q[qid] && hc == tc) begin
							fc_head_q <= tc;
							fc_cnt_q <= fc_cnt_q + 1'b1;
						end
					end
					lcq_pkg::CMD_ENQ: if (q_ok) begin
						if ((!nonempty_q[qid] || to == LASTOFF) && !nomem_chunk) begin
							fc_head_q <= link_rd_s1;
							fc_cnt_q <= fc_cnt_q - 1'b1;
							nonempty_q[qid] <= 1'b1;
						end
					end
					lcq_pkg::CMD_DEQ: if (q_ok && nonempty_q[qid]) begin
						if ((hc == tc && ho == to) || ho == LASTOFF) begin
							fc_head_q <= hc;
							fc_cnt_q <= fc_cnt_q + 1'b1;
						end
						if (hc == tc && ho == to) nonempty_q[qid] <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == lcq_pkg::S_WALK) begin
				fc_head_q <= walk_c_q;
				fc_cnt_q <= fc_cnt_q + 1'b1;
			end
		end
	end

	// Payload registers and memory writes.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) cur_q <= in_data;
		if (init_q && 32'(init_cnt_q) < NUM_CHUNK_SLOTS)
			link_mem[init_cnt_q[CW-1:0]] <= (32'(init_cnt_q) == NUM_CHUNK_SLOTS - 1) ? '0
				: CW'(32'(init_cnt_q) + 1);
		if (state_q == lcq_pkg::S_EXEC) begin
			res_q <= res_d;
			walk_c_q <= hc;
			unique case (cur_q.cmd)
				lcq_pkg::CMD_CREATE: ;
				lcq_pkg::CMD_DESTROY:
					if (q_ok) begin
						if (fq_cnt_q < QCW'(NUM_QUEUE_SLOTS)) fq_mem[fq_cnt_q[QW-1:0]] <= qid;
						if (nonempty_q[qid] && hc == tc) link_mem[tc] <= fc_head_q;
					end
				lcq_pkg::CMD_ENQ:
					if (q_ok) begin
						if (!nonempty_q[qid] || to == LASTOFF) begin
							if (!nomem_chunk) begin
								bytes_mem[{fc_head_q, OW'(0)}] <= cur_q.data_in;
								if (!nonempty_q[qid]) begin
									ptr_mem[qid] <= {fc_head_q, OW'(0), fc_head_q, OW'(0)};
								end else begin
									ptr_mem[qid] <= {hc, ho, fc_head_q, OW'(0)};
									link_mem[tc] <= fc_head_q;
								end
							end
						end else begin
							bytes_mem[{tc, to + OW'(1)}] <= cur_q.data_in;
							ptr_mem[qid] <= {hc, ho, tc, to + OW'(1)};
						end
					end
				lcq_pkg::CMD_DEQ:
					if (q_ok && nonempty_q[qid]) begin
						if (hc == tc && ho == to) link_mem[hc] <= fc_head_q;
						else if (ho == LASTOFF) begin
							ptr_mem[qid] <= {link_rd_s1, OW'(0), tc, to};
							link_mem[hc] <= fc_head_q;
						end else ptr_mem[qid] <= {hc, ho + OW'(1), tc, to};
					end
				default: ;
			endcase
		end
		if (state_q == lcq_pkg::S_WALK) begin
			link_mem[walk_c_q] <= fc_head_q;
			walk_c_q <= link_rd_s1;
		end
		if (out_load) out_data <= res_q;
		if (state_q == lcq_pkg::S_IDLE && init_q && 32'(init_cnt_q) < NUM_QUEUE_SLOTS)
			fq_mem[init_cnt_q[QW-1:0]] <= (init_cnt_q == '0) ? '0
				: QW'(NUM_QUEUE_SLOTS - 32'(init_cnt_q));
	end
endmodule
